// ----- sv/hrhp_pkg.sv -----
package hrhp_pkg;

    localparam int NAME_COUNT   = 6;
    localparam int MAX_NAME_LEN = 16;
    localparam int NAME_POS_W   = $clog2(MAX_NAME_LEN);

    localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

    // result kinds
    localparam logic [1:0] KIND_TARGET    = 2'd0;
    localparam logic [1:0] KIND_VALUE     = 2'd1;
    localparam logic [1:0] KIND_VALUE_END = 2'd2;
    localparam logic [1:0] KIND_DONE      = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_REQUEST = 3'd1;
    localparam logic [2:0] ST_NOT_IMPL    = 3'd2;
    localparam logic [2:0] ST_URI_LONG    = 3'd3;
    localparam logic [2:0] ST_BAD_VERSION = 3'd4;

    localparam logic [2:0] NO_HEADER = 3'd7;

    // configuration register indexes
    localparam logic REG_MAX_LEN = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [2:0]  header_index;
        logic [15:0] value_length;
        logic [2:0]  status;
        logic        method;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    localparam logic [7:0] GET_TAB [3] = '{"G", "E", "T"};
    localparam logic [7:0] HEAD_TAB [4] = '{"H", "E", "A", "D"};
    localparam logic [7:0] V10_TAB [8] = '{"H", "T", "T", "P", "/", "1", ".", "0"};
    localparam logic [7:0] V11_TAB [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

    // known header names, lower case, zero padded
    localparam logic [7:0] NAME_TAB [NAME_COUNT][MAX_NAME_LEN] = '{
        '{"a", "c", "c", "e", "p", "t", 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "a", "c", "h", "e", "-", "c", "o",
          "n", "t", "r", "o", "l", 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "e", "n", "t", "-",
          "t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "e", "n", "t", "-",
          "l", "e", "n", "g", "t", "h", 8'h00, 8'h00},
        '{"h", "o", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "s", "e", "r", "-", "a", "g", "e",
          "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] NAME_CHARS [NAME_COUNT] = '{
        8'd6, 8'd13, 8'd12, 8'd14, 8'd4, 8'd10
    };

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z") begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || (c == 8'h09);
    endfunction

endpackage

// ----- sv/http_request_head_parser_core.sv -----
// HTTP request head parser core.
// Input channel: one byte of the request head per transfer (i_in_valid,
// o_in_stall, i_in_data); last_byte marks the end of the received buffer.
// Output channel: zero or one result per input byte (o_out_valid,
// i_out_stall, o_out_data): target bytes, known header value bytes, a value
// end with the trimmed length, and a done result carrying the status.
// Configuration: APB register 0 (byte address 0) holds max_request_len.
// Path: a taken byte waits in the input register until the output register
// is free or being emptied; the parse logic then puts its result into the
// output register. Throughput: one byte per cycle while the receiver does
// not stall, as the parse logic updates its state for each parsed byte.
// Reset: synchronous, active low; the parser returns to expecting a method,
// both registers empty, max_request_len back to 8192.
// When the receiver stalls, the result is held; the next byte still moves
// into the input register, and only then is o_in_stall raised.
module http_request_head_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hrhp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hrhp_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic                r_in_valid;
    hrhp_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    hrhp_pkg::t_out_item r_out_item;
    logic                fire;
    logic                in_take;
    logic [15:0]         max_len;
    hrhp_pkg::t_result   result;

    hrhp_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    hrhp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in_item),
        .i_max_len (max_len),
        .o_result  (result)
    );

    // parse a byte only when the output register is free or being emptied
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= result.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.valid) begin
            r_out_item <= result.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !fire)
        else $error("held result overwritten");

    a_stall_keeps_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in_item))
        else $error("pending byte lost under stall");

    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("stall raised without a blocked byte");

endmodule

// ----- sv/hrhp_apb_regs.sv -----
module hrhp_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_max_len
);

    logic [15:0] r_max_len;
    logic [15:0] n_max_len;

    always_comb begin
        n_max_len = r_max_len;
        if (psel && penable && pwrite && pready && paddr[2] == hrhp_pkg::REG_MAX_LEN) begin
            n_max_len = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= hrhp_pkg::MAX_LEN_RESET;
        end else begin
            r_max_len <= n_max_len;
        end
    end

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == hrhp_pkg::REG_MAX_LEN) ? {16'd0, r_max_len} : 32'd0;
    assign o_max_len = r_max_len;

endmodule

// ----- sv/hrhp_parse.sv -----
module hrhp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  hrhp_pkg::t_in_item  i_item,
    input  logic [15:0]         i_max_len,
    output hrhp_pkg::t_result   o_result
);

    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_TARGET  = 4'd1;
    localparam logic [3:0] PH_VERSION = 4'd2;
    localparam logic [3:0] PH_VER_CR  = 4'd3;
    localparam logic [3:0] PH_VER_LF  = 4'd4;
    localparam logic [3:0] PH_LINE    = 4'd5;
    localparam logic [3:0] PH_NAME    = 4'd6;
    localparam logic [3:0] PH_LEAD    = 4'd7;
    localparam logic [3:0] PH_VALUE   = 4'd8;
    localparam logic [3:0] PH_VAL_LF  = 4'd9;
    localparam logic [3:0] PH_END_LF  = 4'd10;
    localparam logic [3:0] PH_DRAIN   = 4'd11;

    localparam logic [hrhp_pkg::NAME_COUNT-1:0] ALL_NAMES = '1;
    localparam int NAME_POS_W_L = hrhp_pkg::NAME_POS_W;

    logic [3:0]                    r_phase, n_phase;
    logic [15:0]                   r_byte_count, n_byte_count;
    logic [7:0]                    r_token_pos, n_token_pos;
    logic [1:0]                    r_method_match, n_method_match;
    logic [hrhp_pkg::NAME_COUNT-1:0] r_name_match, n_name_match;
    logic [1:0]                    r_version_match, n_version_match;
    logic [2:0]                    r_current_header, n_current_header;
    logic [15:0]                   r_value_count, n_value_count;
    logic [15:0]                   r_trimmed_count, n_trimmed_count;

    logic [7:0]  b;
    logic [7:0]  lb;
    logic        last;
    logic        do_finish;
    logic        do_start;
    logic [2:0]  fin_status;
    logic        err_valid;
    logic [2:0]  err_code;
    logic [7:0]  name_pos;
    logic [NAME_POS_W_L-1:0] name_idx;
    hrhp_pkg::t_result res;

    function automatic logic [2:0] phase_error(input logic [3:0] ph);
        logic [2:0] r;
        case (ph)
            PH_TARGET, PH_VER_CR, PH_VER_LF: r = hrhp_pkg::ST_URI_LONG;
            PH_VERSION:                      r = hrhp_pkg::ST_BAD_VERSION;
            default:                         r = hrhp_pkg::ST_BAD_REQUEST;
        endcase
        return r;
    endfunction

    assign b    = i_item.data_byte;
    assign lb   = hrhp_pkg::to_lower(i_item.data_byte);
    assign last = i_item.last_byte;

    always_comb begin
        n_phase          = r_phase;
        n_byte_count     = r_byte_count;
        n_token_pos      = r_token_pos;
        n_method_match   = r_method_match;
        n_name_match     = r_name_match;
        n_version_match  = r_version_match;
        n_current_header = r_current_header;
        n_value_count    = r_value_count;
        n_trimmed_count  = r_trimmed_count;
        res              = '0;
        do_finish        = 1'b0;
        do_start         = 1'b0;
        fin_status       = hrhp_pkg::ST_OK;
        err_valid        = 1'b0;
        err_code         = hrhp_pkg::ST_OK;
        name_pos         = r_token_pos;
        name_idx         = '0;

        if (r_phase >= PH_DRAIN) begin
            do_start = last;
        end else if (r_byte_count >= i_max_len) begin
            do_finish  = 1'b1;
            fin_status = phase_error(r_phase);
        end else begin
            n_byte_count = r_byte_count + 16'd1;
            case (r_phase)
                PH_METHOD: begin
                    if (b == " ") begin
                        if (r_token_pos == 8'd3 && r_method_match[0]) begin
                            n_method_match = 2'd1;
                        end else if (r_token_pos == 8'd4 && r_method_match[1]) begin
                            n_method_match = 2'd2;
                        end else begin
                            err_valid = 1'b1;
                            err_code  = hrhp_pkg::ST_NOT_IMPL;
                        end
                        if (!err_valid) begin
                            n_phase     = PH_TARGET;
                            n_token_pos = 8'd0;
                        end
                    end else begin
                        if (r_token_pos >= 8'd3 || b != hrhp_pkg::GET_TAB[r_token_pos[1:0]]) begin
                            n_method_match[0] = 1'b0;
                        end
                        if (r_token_pos >= 8'd4 || b != hrhp_pkg::HEAD_TAB[r_token_pos[1:0]]) begin
                            n_method_match[1] = 1'b0;
                        end
                        if (r_token_pos != 8'hFF) begin
                            n_token_pos = r_token_pos + 8'd1;
                        end
                    end
                end
                PH_TARGET: begin
                    if (b == " ") begin
                        n_phase         = PH_VERSION;
                        n_token_pos     = 8'd0;
                        n_version_match = 2'b11;
                    end else begin
                        res.valid         = 1'b1;
                        res.item.kind     = hrhp_pkg::KIND_TARGET;
                        res.item.out_byte = b;
                    end
                end
                PH_VERSION: begin
                    if (r_token_pos >= 8'd8 || b != hrhp_pkg::V10_TAB[r_token_pos[2:0]]) begin
                        n_version_match[0] = 1'b0;
                    end
                    if (r_token_pos >= 8'd8 || b != hrhp_pkg::V11_TAB[r_token_pos[2:0]]) begin
                        n_version_match[1] = 1'b0;
                    end
                    if (n_version_match == 2'b00) begin
                        err_valid = 1'b1;
                        err_code  = hrhp_pkg::ST_BAD_VERSION;
                    end else begin
                        n_token_pos = r_token_pos + 8'd1;
                        if (n_token_pos >= 8'd8) begin
                            n_phase = PH_VER_CR;
                        end
                    end
                end
                PH_VER_CR: begin
                    if (b == 8'h0D) begin
                        n_phase = PH_VER_LF;
                    end else begin
                        err_valid = 1'b1;
                        err_code  = hrhp_pkg::ST_BAD_REQUEST;
                    end
                end
                PH_VER_LF, PH_VAL_LF: begin
                    if (b == 8'h0A) begin
                        n_phase = PH_LINE;
                    end else begin
                        err_valid = 1'b1;
                        err_code  = hrhp_pkg::ST_BAD_REQUEST;
                    end
                end
                PH_LINE, PH_NAME: begin
                    if (r_phase == PH_LINE && b == 8'h0D) begin
                        n_phase = PH_END_LF;
                    end else begin
                        // a fresh line restarts the name compare
                        if (r_phase == PH_LINE) begin
                            n_name_match = ALL_NAMES;
                            name_pos     = 8'd0;
                        end
                        name_idx = name_pos[NAME_POS_W_L-1:0];
                        if (b == ":") begin
                            n_current_header = hrhp_pkg::NO_HEADER;
                            for (int i = hrhp_pkg::NAME_COUNT - 1; i >= 0; i--) begin
                                if (n_name_match[i] && name_pos == hrhp_pkg::NAME_CHARS[i]) begin
                                    n_current_header = 3'(i);
                                end
                            end
                            n_token_pos     = name_pos;
                            n_value_count   = 16'd0;
                            n_trimmed_count = 16'd0;
                            n_phase         = PH_LEAD;
                        end else begin
                            for (int i = 0; i < hrhp_pkg::NAME_COUNT; i++) begin
                                if (name_pos >= hrhp_pkg::NAME_CHARS[i] ||
                                    name_pos >= 8'(hrhp_pkg::MAX_NAME_LEN) ||
                                    lb != hrhp_pkg::NAME_TAB[i][name_idx]) begin
                                    n_name_match[i] = 1'b0;
                                end
                            end
                            n_token_pos = (name_pos != 8'hFF) ? name_pos + 8'd1 : name_pos;
                            n_phase     = PH_NAME;
                        end
                    end
                end
                PH_LEAD, PH_VALUE: begin
                    if (b == 8'h0D) begin
                        n_phase = PH_VAL_LF;
                        if (r_current_header < 3'(hrhp_pkg::NAME_COUNT)) begin
                            res.valid             = 1'b1;
                            res.item.kind         = hrhp_pkg::KIND_VALUE_END;
                            res.item.header_index = r_current_header;
                            res.item.value_length = r_trimmed_count;
                        end
                    end else if (r_phase == PH_VALUE || !hrhp_pkg::is_ws(b)) begin
                        if (r_value_count != 16'hFFFF) begin
                            n_value_count = r_value_count + 16'd1;
                        end
                        if (!hrhp_pkg::is_ws(b)) begin
                            n_trimmed_count = n_value_count;
                        end
                        n_phase = PH_VALUE;
                        if (r_current_header < 3'(hrhp_pkg::NAME_COUNT)) begin
                            res.valid             = 1'b1;
                            res.item.kind         = hrhp_pkg::KIND_VALUE;
                            res.item.out_byte     = b;
                            res.item.header_index = r_current_header;
                        end
                    end
                end
                default: begin
                    // final LF of the blank line
                    err_valid = 1'b1;
                    err_code  = (b == 8'h0A) ? hrhp_pkg::ST_OK : hrhp_pkg::ST_BAD_REQUEST;
                end
            endcase

            if (err_valid) begin
                do_finish  = 1'b1;
                fin_status = err_code;
            end else if (last) begin
                do_finish  = 1'b1;
                fin_status = phase_error(n_phase);
            end
        end

        if (do_finish) begin
            res                   = '0;
            res.valid             = 1'b1;
            res.item.kind         = hrhp_pkg::KIND_DONE;
            res.item.status       = fin_status;
            res.item.method       = (fin_status == hrhp_pkg::ST_OK) && (n_method_match == 2'd2);
            if (last) begin
                do_start = 1'b1;
            end else begin
                n_phase = PH_DRAIN;
            end
        end

        if (do_start) begin
            n_phase          = PH_METHOD;
            n_byte_count     = 16'd0;
            n_token_pos      = 8'd0;
            n_method_match   = 2'b11;
            n_name_match     = ALL_NAMES;
            n_version_match  = 2'b11;
            n_current_header = hrhp_pkg::NO_HEADER;
            n_value_count    = 16'd0;
            n_trimmed_count  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_METHOD;
            r_byte_count     <= 16'd0;
            r_token_pos      <= 8'd0;
            r_method_match   <= 2'b11;
            r_name_match     <= ALL_NAMES;
            r_version_match  <= 2'b11;
            r_current_header <= hrhp_pkg::NO_HEADER;
            r_value_count    <= 16'd0;
            r_trimmed_count  <= 16'd0;
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_token_pos      <= n_token_pos;
            r_method_match   <= n_method_match;
            r_name_match     <= n_name_match;
            r_version_match  <= n_version_match;
            r_current_header <= n_current_header;
            r_value_count    <= n_value_count;
            r_trimmed_count  <= n_trimmed_count;
        end
    end

    assign o_result = res;

    // the drain phase never emits anything
    a_drain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_DRAIN) |-> !res.valid)
        else $error("result produced while draining");

endmodule
